// ----- hw/rtl/swa_pkg.sv -----
// Shared constants and width helpers for the sliding window average core.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package swa_pkg;

  // Width and reset value of the window size register.
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd4;

  // Fixed point format of the average.
  localparam int FRAC_BITS = 16;
  localparam int AVG_W     = 32;

  // Depth of the queue between the front and back parts.
  localparam int Q_DEPTH = 2;

  // Defaults for the top level parameters.
  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // Address width of a store with the given depth (at least one bit).
  function automatic int addr_bits(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // Width that holds a fill count from 0 up to the window maximum.
  function automatic int fill_bits(input int wmax);
    return $clog2(wmax + 1);
  endfunction

  // Signed width that holds the sum of up to wmax samples.
  function automatic int sum_bits(input int sbits, input int wmax);
    return sbits + $clog2(wmax);
  endfunction

  // Width of one queue entry: running sum and fill count.
  function automatic int entry_bits(input int sbits, input int wmax);
    return sum_bits(sbits, wmax) + fill_bits(wmax);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/swa_ram.sv -----
// Generic single write port, single read port RAM with a registered read.
// Depends on swa_pkg for its address width; used for the sample ring.
`default_nettype none

module swa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [swa_pkg::addr_bits(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic [swa_pkg::addr_bits(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/swa_front.sv -----
// Front part: window register, sample ring, running sum and fill count.
// Depends on swa_pkg and swa_ram; pushes (sum, fill) pairs to the queue.
`default_nettype none

module swa_front #(
  parameter int WINDOW_MAX  = swa_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                                 clk,
  input  wire logic                                                 rst,
  input  wire logic                                                 cfg_valid,
  output logic                                                      cfg_ready,
  input  wire logic [swa_pkg::CFG_W-1:0]                            cfg_data,
  input  wire logic                                                 in_valid,
  output logic                                                      in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0]                        sample,
  output logic                                                      q_valid,
  input  wire logic                                                 q_ready,
  output logic [swa_pkg::entry_bits(SAMPLE_BITS, WINDOW_MAX)-1:0]   q_data
);

  import swa_pkg::*;

  localparam int AW    = addr_bits(WINDOW_MAX);
  localparam int FW    = fill_bits(WINDOW_MAX);
  localparam int SW    = sum_bits(SAMPLE_BITS, WINDOW_MAX);
  localparam int CMP_W = (FW > CFG_W) ? FW : CFG_W;
  localparam int OW    = FW + 1;

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_UPD  = 2'b10
  } front_state_t;

  front_state_t            state;
  logic [CFG_W-1:0]        window_size;
  logic [AW-1:0]           write_slot;
  logic [FW-1:0]           held_count;
  logic signed [SW-1:0]    window_sum;
  logic signed [SAMPLE_BITS-1:0] sample_q;

  logic [FW-1:0]           win_eff;
  logic [OW-1:0]           oldest_raw;
  logic [OW-1:0]           oldest_wrap;
  logic [AW-1:0]           oldest;
  logic                    drop;
  logic [SAMPLE_BITS-1:0]  ring_rdata;
  logic [AW-1:0]           write_slot_next;
  logic [FW-1:0]           held_count_next;
  logic signed [SW-1:0]    window_sum_next;
  logic signed [SW-1:0]    drop_value;

  // Window of zero counts as one; above the maximum it saturates.
  always_comb begin
    if (window_size == '0) begin
      win_eff = FW'(1);
    end else if (CMP_W'(window_size) > CMP_W'(WINDOW_MAX)) begin
      win_eff = FW'(WINDOW_MAX);
    end else begin
      win_eff = FW'(window_size);
    end
  end

  // Oldest held slot, write_slot - window taken modulo the ring depth.
  always_comb begin
    oldest_raw  = OW'(write_slot) + OW'(WINDOW_MAX) - OW'(win_eff);
    oldest_wrap = (oldest_raw >= OW'(WINDOW_MAX)) ? oldest_raw - OW'(WINDOW_MAX) : oldest_raw;
    oldest      = oldest_wrap[AW-1:0];
  end

  assign drop = (held_count >= win_eff);

  always_comb begin
    drop_value      = drop ? SW'($signed(ring_rdata)) : '0;
    window_sum_next = window_sum - drop_value + SW'(sample_q);
    held_count_next = drop ? win_eff : held_count + FW'(1);
    write_slot_next = (write_slot == AW'(WINDOW_MAX - 1)) ? '0 : write_slot + AW'(1);
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == F_IDLE) && q_ready && !cfg_valid;
  assign q_valid   = (state == F_UPD);
  assign q_data    = {window_sum_next, held_count_next};

  // The oldest entry is read in the accept cycle and arrives in the update cycle.
  swa_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (state == F_UPD),
    .waddr (write_slot),
    .wdata (sample_q),
    .raddr (oldest),
    .rdata (ring_rdata)
  );

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample_q <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= F_IDLE;
      window_size <= WINDOW_RESET;
      write_slot  <= '0;
      held_count  <= '0;
      window_sum  <= '0;
    end else begin
      // Every register write restarts the window. An update in flight has
      // already handed its result to the queue, so the restart wins.
      if (cfg_valid) begin
        window_size <= cfg_data;
        write_slot  <= '0;
        held_count  <= '0;
        window_sum  <= '0;
      end else if (state == F_UPD) begin
        write_slot <= write_slot_next;
        held_count <= held_count_next;
        window_sum <= window_sum_next;
      end
      case (state)
        F_IDLE: begin
          if (in_valid && in_ready) begin
            state <= F_UPD;
          end
        end
        F_UPD: begin
          state <= F_IDLE;
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  a_held_in_window: assert property (@(posedge clk) disable iff (rst)
    held_count <= win_eff)
    else $error("fill count exceeds the effective window");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    (state == F_UPD) |-> q_ready)
    else $error("queue full when the front part pushes its update");

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> !in_ready)
    else $error("sample accepted together with a window write");

endmodule

`default_nettype wire

// ----- hw/rtl/swa_queue.sv -----
// Short queue between the front and back parts.
// Depends on swa_pkg for its depth.
`default_nettype none

module swa_queue #(
  parameter int WIDTH = 29
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  import swa_pkg::*;

  localparam int PW = addr_bits(Q_DEPTH);
  localparam int CW = $clog2(Q_DEPTH + 1);

  logic [WIDTH-1:0] entries [Q_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CW'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/swa_div.sv -----
// Back part: bit-serial signed divide of sum * 2^16 by the fill count,
// saturation to 32 bits and the output register. Depends on swa_pkg.
`default_nettype none

module swa_div #(
  parameter int WINDOW_MAX  = swa_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                               clk,
  input  wire logic                                               rst,
  input  wire logic                                               q_valid,
  output logic                                                    q_ready,
  input  wire logic [swa_pkg::entry_bits(SAMPLE_BITS, WINDOW_MAX)-1:0] q_data,
  output logic                                                    out_valid,
  input  wire logic                                               out_ready,
  output logic signed [swa_pkg::AVG_W-1:0]                        average,
  output logic [swa_pkg::fill_bits(WINDOW_MAX)-1:0]               fill
);

  import swa_pkg::*;

  localparam int FW    = fill_bits(WINDOW_MAX);
  localparam int SW    = sum_bits(SAMPLE_BITS, WINDOW_MAX);
  localparam int DVD_W = SW + FRAC_BITS;
  localparam int CW    = $clog2(DVD_W);
  localparam int WIDE  = (DVD_W + 1 > AVG_W + 1) ? DVD_W + 1 : AVG_W + 1;

  localparam logic signed [AVG_W-1:0] AVG_MAX32 = {1'b0, {(AVG_W-1){1'b1}}};
  localparam logic signed [AVG_W-1:0] AVG_MIN32 = {1'b1, {(AVG_W-1){1'b0}}};
  localparam logic signed [WIDE-1:0]  AVG_MAX   = WIDE'(AVG_MAX32);
  localparam logic signed [WIDE-1:0]  AVG_MIN   = WIDE'(AVG_MIN32);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_RUN  = 3'b010,
    B_DONE = 3'b100
  } back_state_t;

  back_state_t         state;
  logic [CW-1:0]       cnt;
  logic [DVD_W-1:0]    dvd;
  logic [FW-1:0]       rem;
  logic [FW-1:0]       divisor;
  logic                neg;

  logic signed [SW-1:0] q_sum;
  logic [FW-1:0]        q_fill;
  logic [SW-1:0]        q_mag;
  logic [FW:0]          rem_sh;
  logic                 ge;
  logic [FW:0]          rem_sub;
  logic signed [WIDE-1:0] quot;
  logic signed [AVG_W-1:0] avg_sat;

  assign q_sum   = q_data[FW +: SW];
  assign q_fill  = q_data[FW-1:0];
  assign q_mag   = q_sum[SW-1] ? SW'(-q_sum) : SW'(q_sum);
  assign q_ready = (state == B_IDLE);

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    rem_sh  = {rem, dvd[DVD_W-1]};
    ge      = (rem_sh >= {1'b0, divisor});
    rem_sub = rem_sh - {1'b0, divisor};
  end

  // Quotient magnitude sits in dvd once all steps are done.
  always_comb begin
    quot = neg ? -$signed(WIDE'(dvd)) : $signed(WIDE'(dvd));
    if (quot > AVG_MAX) begin
      avg_sat = AVG_MAX32;
    end else if (quot < AVG_MIN) begin
      avg_sat = AVG_MIN32;
    end else begin
      avg_sat = AVG_W'(quot);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          dvd     <= {q_mag, FRAC_BITS'(0)};
          rem     <= '0;
          divisor <= q_fill;
          neg     <= q_sum[SW-1];
        end
      end
      B_RUN: begin
        dvd <= {dvd[DVD_W-2:0], ge};
        rem <= ge ? rem_sub[FW-1:0] : rem_sh[FW-1:0];
      end
      B_DONE: begin
        if (!out_valid || out_ready) begin
          average <= avg_sat;
          fill    <= divisor;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // A finished divide refills the output register as it empties.
      if (state == B_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            cnt   <= '0;
            state <= B_RUN;
          end
        end
        B_RUN: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(DVD_W - 1)) begin
            state <= B_DONE;
          end
        end
        B_DONE: begin
          if (!out_valid || out_ready) begin
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == B_RUN) |-> (rem < divisor))
    else $error("partial remainder not below the divisor");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == B_RUN) |-> (divisor != '0))
    else $error("divide started with a zero fill count");

  a_valid_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == B_DONE))
    else $error("result shown without a finished divide");

endmodule

`default_nettype wire

// ----- hw/rtl/sliding_window_average_core.sv -----
// Top level of the sliding window average core: front part, queue, back part.
// Depends on swa_pkg, swa_front, swa_queue and swa_div.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+-------------------------------
//   cfg     | in        | cfg_valid/cfg_ready  | cfg_data: window size, 7 bits
//   in      | in        | in_valid/in_ready    | sample: signed SAMPLE_BITS
//   out     | out       | out_valid/out_ready  | average: signed 32, fill
//
// The front part takes a request in its idle state and updates the ring and
// the running sum in its update state; it takes no new sample before that
// update. The back part divides one bit per cycle over a dividend of SUM_W + 16
// bits, SUM_W = SAMPLE_BITS + clog2(WINDOW_MAX), and its slow divide sets the
// sustained rate. Synchronous reset sets the window to 4 and empties it; the
// ring needs no clearing pass. The two-entry queue and the output register let
// the front keep taking samples while a result waits on out_ready.
`default_nettype none

module sliding_window_average_core #(
  parameter int WINDOW_MAX  = swa_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [swa_pkg::CFG_W-1:0]             cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0]         sample,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [swa_pkg::AVG_W-1:0]           average,
  output logic [swa_pkg::fill_bits(WINDOW_MAX)-1:0]  fill
);

  import swa_pkg::*;

  localparam int ENT_W = entry_bits(SAMPLE_BITS, WINDOW_MAX);

  // Front to queue.
  logic             push_valid;
  logic             push_ready;
  logic [ENT_W-1:0] push_data;

  // Queue to back.
  logic             pop_valid;
  logic             pop_ready;
  logic [ENT_W-1:0] pop_data;

  // The front part owns the window register and the ring. Each accepted
  // sample yields one queue entry with the updated sum and fill count.
  swa_front #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .q_valid   (push_valid),
    .q_ready   (push_ready),
    .q_data    (push_data)
  );

  // A short queue decouples the sum update from the slow divide.
  swa_queue #(
    .WIDTH (ENT_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // The back part turns each entry into a mean with 16 fraction bits,
  // truncated toward zero, and holds it in the output register.
  swa_div #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_data    (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .average   (average),
    .fill      (fill)
  );

endmodule

`default_nettype wire

// ----- test/tb_sliding_window_average_core.sv -----
// Testbench for sliding_window_average_core: drives samples and window size
// writes, predicts every average and fill, and checks each result in order.
// Depends on swa_pkg and the sliding_window_average_core RTL only.
`timescale 1ns / 1ps

module tb_sliding_window_average_core;

  import swa_pkg::*;

  localparam int WINDOW_MAX  = WINDOW_MAX_DEF;
  localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
  localparam int FILL_W      = fill_bits(WINDOW_MAX);

  // A window size write waits this many quiet cycles after the last result.
  localparam int SETTLE_CYCLES = 8;
  // Length of the long output stall that backs the core up.
  localparam int HOLD_CYCLES   = 400;
  // Samples in each random segment, and the number of segments.
  localparam int SEG_ITEMS     = 115;
  localparam int SEG_COUNT     = 13;

  // Limits of a 32-bit signed average.
  localparam longint AVG_HI = 64'sd2147483647;
  localparam longint AVG_LO = -AVG_HI - 64'sd1;

  // Kinds of entries in the stimulus queue. Only samples and window writes
  // become requests on the ports; the others steer the driver and receiver.
  typedef enum logic [2:0] {
    CMD_SAMPLE,
    CMD_WINDOW,
    CMD_DRAIN,
    CMD_HOLD,
    CMD_PHASE
  } cmd_kind_t;

  typedef struct {
    cmd_kind_t        kind;
    logic [15:0]      data;
    int               send_idle;
    int               recv_idle;
  } cmd_t;

  typedef struct {
    logic signed [AVG_W-1:0] average;
    logic [FILL_W-1:0]       fill;
  } avg_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_W-1:0]              cfg_data  = '0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] sample    = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [AVG_W-1:0]       average;
  logic [FILL_W-1:0]             fill;

  sliding_window_average_core #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sample   (sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .average  (average),
    .fill     (fill)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stimulus waiting for the driver, and averages waiting for the core.
  cmd_t     pending_cmds[$];
  avg_rec_t expected_avgs[$];

  // Both counters move by nonblocking assignment, so either process reads a
  // stable value at a clock edge. Their difference is the number of samples
  // inside the core.
  int unsigned samples_sent    = 0;
  int unsigned averages_seen   = 0;
  int unsigned error_count     = 0;

  int   recv_idle_pct = 74;
  int   send_idle_pct = 16;
  logic hold_start    = 1'b0;

  // --------------------------------------------------------------------------
  // Predictor: a private copy of the ring, the running sum and the fill count.
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] ring_copy [0:WINDOW_MAX-1];
  logic [5:0]                    next_slot;
  logic [6:0]                    held;
  logic signed [22:0]            window_total;
  logic [CFG_W-1:0]              window_reg;

  // A window of zero acts as one, and anything past the maximum saturates.
  function automatic logic [6:0] active_window(input logic [CFG_W-1:0] w);
    if (w == 0) return 7'd1;
    if (w > WINDOW_MAX) return 7'(WINDOW_MAX);
    return w;
  endfunction

  // Every write restarts the window, even when the size does not change.
  task automatic restart_window(input logic [CFG_W-1:0] w);
    window_reg   = w;
    next_slot    = '0;
    held         = '0;
    window_total = '0;
  endtask

  task automatic predict_average(input logic signed [SAMPLE_BITS-1:0] s);
    logic [6:0] w;
    logic [5:0] oldest;
    longint     scaled;
    longint     quot;
    avg_rec_t   rec;
    w = active_window(window_reg);
    // A full window drops its oldest sample before taking the new one. With a
    // window of 64 the oldest sample sits in the slot about to be written.
    if (held >= w) begin
      oldest       = next_slot - w[5:0];
      window_total = window_total - ring_copy[oldest];
      held         = w - 7'd1;
    end
    ring_copy[next_slot] = s;
    next_slot    = next_slot + 6'd1;
    window_total = window_total + s;
    held         = held + 7'd1;
    // SystemVerilog division truncates toward zero, as the core must.
    scaled      = longint'(window_total) * 65536;
    quot        = scaled / longint'(held);
    if (quot > AVG_HI) quot = AVG_HI;
    if (quot < AVG_LO) quot = AVG_LO;
    rec.average = quot[AVG_W-1:0];
    rec.fill    = held;
    expected_avgs = {expected_avgs, rec};
  endtask

  // --------------------------------------------------------------------------
  // Stimulus construction.
  // --------------------------------------------------------------------------
  task automatic queue_cmd(input cmd_kind_t k, input logic [15:0] d,
                           input int si = 0, input int ri = 0);
    cmd_t c;
    c.kind      = k;
    c.data      = d;
    c.send_idle = si;
    c.recv_idle = ri;
    pending_cmds = {pending_cmds, c};
  endtask

  // Random samples lean on the extremes, where the sum is widest, and on
  // small values near zero, where truncation toward zero shows most.
  function automatic logic [15:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'(int'($urandom_range(0, 6)) - 3);
      default: return 16'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: takes at most one entry from the stimulus queue, and only while no
  // request is outstanding on either input channel. Accepted requests are fed
  // to the predictor at the edge where they are taken.
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin : driver
    cmd_t head;
    logic nxt_in_valid;
    logic nxt_cfg_valid;
    logic nxt_hold;
    nxt_in_valid  = in_valid;
    nxt_cfg_valid = cfg_valid;
    nxt_hold      = 1'b0;
    if (rst) begin
      restart_window(WINDOW_RESET);
      nxt_in_valid  = 1'b0;
      nxt_cfg_valid = 1'b0;
      quiet_cycles  = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_average(sample);
        samples_sent <= samples_sent + 1;
        nxt_in_valid = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        restart_window(cfg_data);
        nxt_cfg_valid = 1'b0;
      end
      // The core is quiet when no request waits and every sample has its
      // result, counting the requests and results taken at this very edge.
      if (!nxt_in_valid && !nxt_cfg_valid &&
          (samples_sent + (in_valid && in_ready) ==
           averages_seen + (out_valid && out_ready)))
        quiet_cycles = quiet_cycles + 1;
      else
        quiet_cycles = 0;

      if (!nxt_in_valid && !nxt_cfg_valid && pending_cmds.size() > 0) begin
        head = pending_cmds[0];
        case (head.kind)
          CMD_SAMPLE: begin
            if ($urandom_range(0, 99) >= send_idle_pct) begin
              sample <= head.data;
              nxt_in_valid = 1'b1;
              void'(pending_cmds.pop_front());
            end
          end
          // The window size changes only with the core empty and settled.
          CMD_WINDOW: begin
            if (quiet_cycles >= SETTLE_CYCLES) begin
              cfg_data <= head.data[CFG_W-1:0];
              nxt_cfg_valid = 1'b1;
              void'(pending_cmds.pop_front());
            end
          end
          // Pause the sample stream until every average is back.
          CMD_DRAIN: begin
            if (quiet_cycles >= 1) void'(pending_cmds.pop_front());
          end
          CMD_HOLD: begin
            nxt_hold = 1'b1;
            void'(pending_cmds.pop_front());
          end
          CMD_PHASE: begin
            send_idle_pct = head.send_idle;
            recv_idle_pct <= head.recv_idle;
            void'(pending_cmds.pop_front());
          end
          default: void'(pending_cmds.pop_front());
        endcase
      end
    end
    in_valid   <= nxt_in_valid;
    cfg_valid  <= nxt_cfg_valid;
    hold_start <= nxt_hold;
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each accepted result against the oldest prediction and
  // drives out_ready, including the long stall that the driver can request.
  // --------------------------------------------------------------------------
  int hold_left = 0;

  always @(posedge clk) begin : monitor
    avg_rec_t want;
    int       nxt_hold_left;
    nxt_hold_left = hold_left;
    if (rst) begin
      out_ready     <= 1'b0;
      nxt_hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        averages_seen <= averages_seen + 1;
        if (expected_avgs.size() == 0) begin
          $error("unexpected result: average %0d fill %0d", average, fill);
          error_count = error_count + 1;
        end else begin
          want = expected_avgs.pop_front();
          if (average !== want.average) begin
            $error("average mismatch: expected %0d, got %0d", want.average, average);
            error_count = error_count + 1;
          end
          if (fill !== want.fill) begin
            $error("fill mismatch: expected %0d, got %0d", want.fill, fill);
            error_count = error_count + 1;
          end
        end
      end
      if (hold_start)
        nxt_hold_left = HOLD_CYCLES;
      else if (nxt_hold_left > 0)
        nxt_hold_left = nxt_hold_left - 1;
      out_ready <= (nxt_hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
    hold_left <= nxt_hold_left;
  end

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin : sequencer
    logic [CFG_W-1:0] seg_window [0:SEG_COUNT-1];
    seg_window = '{7'd64, 7'd1, 7'd2, 7'd127, 7'd0, 7'd4, 7'd4, 7'd3, 7'd65,
                   7'd64, 7'($urandom_range(0, 127)), 7'($urandom_range(1, 64)),
                   7'd33};

    queue_cmd(CMD_PHASE, '0, 16, 74);

    // Directed part under the reset window of four: both extremes long enough
    // to fill and slide the window, then values around zero and bit patterns.
    repeat (5) queue_cmd(CMD_SAMPLE, 16'h7FFF);
    repeat (5) queue_cmd(CMD_SAMPLE, 16'h8000);
    queue_cmd(CMD_SAMPLE, 16'h0000);
    queue_cmd(CMD_SAMPLE, 16'hFFFF);
    queue_cmd(CMD_SAMPLE, 16'h0001);
    queue_cmd(CMD_SAMPLE, 16'hFFFE);
    queue_cmd(CMD_SAMPLE, 16'h5555);
    queue_cmd(CMD_SAMPLE, 16'hAAAA);
    // A window of zero behaves as a window of one.
    queue_cmd(CMD_WINDOW, 16'd0);
    queue_cmd(CMD_SAMPLE, 16'h8000);
    queue_cmd(CMD_SAMPLE, 16'h7FFF);
    queue_cmd(CMD_SAMPLE, 16'hFFFF);
    // An oversized window is clipped to the maximum.
    queue_cmd(CMD_WINDOW, 16'd127);
    queue_cmd(CMD_SAMPLE, 16'hFFFF);
    queue_cmd(CMD_SAMPLE, 16'h0002);
    queue_cmd(CMD_SAMPLE, 16'h8000);

    // Random segments, each under its own window size. Idling moves from a
    // slow receiver to a slow sender and then to neither.
    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      if (seg == 5) queue_cmd(CMD_PHASE, '0, 74, 16);
      if (seg == 9) queue_cmd(CMD_PHASE, '0, 0, 0);
      queue_cmd(CMD_WINDOW, 16'(seg_window[seg]));
      for (int i = 0; i < SEG_ITEMS; i++) begin
        if ((seg == 2 || seg == 6) && i == SEG_ITEMS / 2) queue_cmd(CMD_DRAIN, '0);
        if (seg == 9 && i == 20) queue_cmd(CMD_HOLD, '0);
        queue_cmd(CMD_SAMPLE, random_sample());
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() > 0 || in_valid || cfg_valid) @(posedge clk);
    while (samples_sent != averages_seen) @(posedge clk);
    repeat (100) @(posedge clk);

    if (expected_avgs.size() != 0) begin
      $error("%0d averages never arrived", expected_avgs.size());
      error_count = error_count + 1;
    end
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // The watchdog ends a run that has not finished in time, reporting a failure.
  initial begin : watchdog
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- sliding_window_average_core.f -----
hw/rtl/swa_pkg.sv
hw/rtl/swa_ram.sv
hw/rtl/swa_front.sv
hw/rtl/swa_queue.sv
hw/rtl/swa_div.sv
hw/rtl/sliding_window_average_core.sv
test/tb_sliding_window_average_core.sv
